FILE: design/ephemeris_validity_times_assert.svh
// Assertion macros shared by the ephemeris validity RTL.
// Plain text only; no dependencies.
`ifndef EPHEMERIS_VALIDITY_TIMES_ASSERT_SVH
`define EPHEMERIS_VALIDITY_TIMES_ASSERT_SVH

// Property checked outside reset.
`define EVT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define EVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/evt_pkg.sv
// Constants, system codes and small helpers for the ephemeris validity block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package evt_pkg;

    typedef enum logic [2:0] {
        SYS_GPS   = 3'd0,
        SYS_GAL   = 3'd1,
        SYS_GLO   = 3'd2,
        SYS_BDS   = 3'd3,
        SYS_QZSS  = 3'd4,
        SYS_IRN   = 3'd5,
        SYS_OTHER = 3'd6
    } t_sys;

    localparam logic [19:0] SECS_WEEK        = 20'd604800;
    localparam logic [19:0] SECS_DAY         = 20'd86400;
    localparam int          DAYS_PER_WEEK    = 7;
    localparam logic [19:0] SECS_FRAME       = 20'd30;
    localparam logic [19:0] SECS_TWO_HOURS   = 20'd7200;
    localparam logic [19:0] SECS_QUARTER_HR  = 20'd900;
    localparam logic [20:0] SECS_HALF_HOUR   = 21'd1800;
    localparam logic [20:0] SECS_HOUR        = 21'd3600;
    localparam logic [20:0] GAL_VALID_SECS   = 21'd14400;
    localparam logic [15:0] GAL_WEEK_SHIFT   = 16'd1024;
    localparam logic signed [20:0] HALF_WEEK = 21'sd302400;

    // Reciprocals: floor(x / d) = (x * RECIP) >> SHIFT, exact for x < 604800.
    localparam logic [20:0] RECIP_30   = 21'd1118482;   // shift 25
    localparam logic [20:0] RECIP_900  = 21'd1193047;   // shift 30
    localparam logic [20:0] RECIP_7200 = 21'd1193047;   // shift 33

    function automatic logic [19:0] sow_reduce(input logic [19:0] v);
        return (v >= SECS_WEEK) ? v - SECS_WEEK : v;
    endfunction

    // True when s is a whole day inside the week.
    function automatic logic is_day_mark(input logic [19:0] s);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < DAYS_PER_WEEK; i++) begin
            hit = hit | (s == 20'(SECS_DAY * i));
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: design/ephemeris_validity_times.sv
// Ephemeris validity times: five-stage pipeline from navigation record to
// transmit, epoch, begin and end times. Depends on evt_pkg and the assert header.
// Usage:
//   Input channel  i_valid / o_ready carries one record (system, week, HOW,
//   Toc, Toe, fit hours). Output channel o_valid / i_ready carries one result
//   per record, in order.
//   An accepted record passes through the five register stages in order
//   (reduce and nudge, reciprocal multiplies, floors, end sums, wrap and
//   output) before o_valid. Throughput: one item per cycle while the receiver
//   is not stalling.
//   Each stage advances when it is empty or the stage after it advances, so
//   a stalled receiver fills the pipe one stage at a time; o_ready drops only
//   when all five stages hold items. Bubbles are squeezed out, nothing is lost.
//   Reset (i_rst_n low, synchronous) empties every stage; o_valid is low in
//   the cycle after reset and o_ready is high.
//   System codes without a rule give o_valid_res low and all other fields 0.
`timescale 1ns / 1ps
`default_nettype none

`include "ephemeris_validity_times_assert.svh"

module ephemeris_validity_times (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_system,
    input  wire logic [13:0]        i_week_number,
    input  wire logic [19:0]        i_how_sow,
    input  wire logic [19:0]        i_toc_sow,
    input  wire logic [19:0]        i_toe_sow,
    input  wire logic [7:0]         i_fit_hours,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_valid_res,
    output logic signed [15:0]      o_xmit_week,
    output logic [19:0]             o_xmit_sow,
    output logic signed [15:0]      o_epoch_week,
    output logic signed [15:0]      o_begin_week,
    output logic [19:0]             o_begin_sow,
    output logic signed [15:0]      o_end_week,
    output logic [19:0]             o_end_sow
);
    import evt_pkg::*;

    // stage valid bits and load enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // ---------------- stage 1: reduce, system decode, day-boundary nudge
    logic               n1_gps, n1_gal, n1_ok;
    logic [19:0]        n1_how, n1_toc, n1_toe, n1_adj;
    logic signed [15:0] n1_week;
    logic               n1_nudge;

    logic               r1_gps, r1_gal, r1_ok;
    logic [19:0]        r1_adj, r1_toe;
    logic signed [15:0] r1_week;
    logic [7:0]         r1_fit;

    always_comb begin
        n1_gps = 1'b0;
        n1_gal = 1'b0;
        n1_ok  = 1'b1;
        unique case (i_system) inside
            SYS_GPS: n1_gps = 1'b1;
            SYS_GAL: n1_gal = 1'b1;
            SYS_GLO, SYS_BDS, SYS_QZSS, SYS_IRN: n1_ok = 1'b1;
            default: n1_ok = 1'b0;
        endcase

        n1_how   = sow_reduce(i_how_sow);
        n1_toc   = sow_reduce(i_toc_sow);
        n1_toe   = sow_reduce(i_toe_sow);
        n1_nudge = is_day_mark(n1_how) && (n1_toc == n1_how);

        n1_week = $signed({2'b00, i_week_number});
        if (n1_gal) n1_week = n1_week - $signed(GAL_WEEK_SHIFT);

        n1_adj = n1_how;
        if (n1_nudge) begin
            if (n1_how == '0) begin
                // borrow a week
                n1_adj  = SECS_WEEK - SECS_FRAME;
                n1_week = n1_week - 16'sd1;
            end else begin
                n1_adj = n1_how - SECS_FRAME;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_gps  <= n1_gps;
            r1_gal  <= n1_gal;
            r1_ok   <= n1_ok;
            r1_adj  <= n1_adj;
            r1_toe  <= n1_toe;
            r1_week <= n1_week;
            r1_fit  <= i_fit_hours;
        end
    end

    // ---------------- stage 2: quotients by 30 and by 900
    logic [40:0]        n2_p30, n2_p900;

    logic               r2_gps, r2_gal, r2_ok;
    logic [19:0]        r2_adj, r2_toe;
    logic signed [15:0] r2_week;
    logic [7:0]         r2_fit;
    logic [14:0]        r2_q30;
    logic [9:0]         r2_q900;

    assign n2_p30  = {21'd0, r1_adj} * {20'd0, RECIP_30};
    assign n2_p900 = {21'd0, r1_toe} * {20'd0, RECIP_900};

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_gps  <= r1_gps;
            r2_gal  <= r1_gal;
            r2_ok   <= r1_ok;
            r2_adj  <= r1_adj;
            r2_toe  <= r1_toe;
            r2_week <= r1_week;
            r2_fit  <= r1_fit;
            r2_q30  <= n2_p30[39:25];
            r2_q900 <= n2_p900[39:30];
        end
    end

    // ---------------- stage 3: transmit second, nominal Toe, next 900 s mark
    logic [19:0]        n3_xsow, n3_rem900, n3_base;
    logic               n3_nominal;

    logic               r3_gps, r3_gal, r3_ok, r3_nominal;
    logic [19:0]        r3_xsow, r3_toe, r3_base;
    logic signed [15:0] r3_week;
    logic [7:0]         r3_fit;

    always_comb begin
        n3_xsow    = r2_gps ? 20'(r2_q30) * SECS_FRAME : r2_adj;
        n3_rem900  = r2_toe - 20'(r2_q900) * SECS_QUARTER_HR;
        // Toe on an even two hours: whole quarter hour, quarter count divisible by 8
        n3_nominal = (n3_rem900 == '0) && (r2_q900[2:0] == 3'd0);
        n3_base    = n3_nominal ? r2_toe : (20'(r2_q900) + 20'd1) * SECS_QUARTER_HR;
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_gps     <= r2_gps;
            r3_gal     <= r2_gal;
            r3_ok      <= r2_ok;
            r3_nominal <= n3_nominal;
            r3_xsow    <= n3_xsow;
            r3_toe     <= r2_toe;
            r3_base    <= n3_base;
            r3_week    <= r2_week;
            r3_fit     <= r2_fit;
        end
    end

    // ---------------- stage 4: epoch week, raw end second, quotient by 7200
    logic signed [20:0] n4_diff;
    logic signed [15:0] n4_eweek;
    logic [20:0]        n4_esow;
    logic [40:0]        n4_p7200;

    logic               r4_gps, r4_ok, r4_nominal;
    logic [19:0]        r4_xsow;
    logic signed [15:0] r4_week, r4_eweek, r4_endw;
    logic [20:0]        r4_esow;
    logic [6:0]         r4_q7200;

    assign n4_p7200 = {21'd0, r3_xsow} * {20'd0, RECIP_7200};

    always_comb begin
        n4_diff  = $signed({1'b0, r3_toe}) - $signed({1'b0, r3_xsow});
        n4_eweek = r3_week;
        if (n4_diff < -HALF_WEEK) begin
            n4_eweek = r3_week + 16'sd1;
        end else if (n4_diff > HALF_WEEK) begin
            n4_eweek = r3_week - 16'sd1;
        end

        if (r3_gps) begin
            n4_esow = {1'b0, r3_base} + 21'(r3_fit) * SECS_HALF_HOUR;
        end else if (r3_gal) begin
            n4_esow = {1'b0, r3_xsow} + GAL_VALID_SECS;
        end else begin
            n4_esow = {1'b0, r3_toe} + 21'(r3_fit[7:1]) * SECS_HOUR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_gps     <= r3_gps;
            r4_ok      <= r3_ok;
            r4_nominal <= r3_nominal;
            r4_xsow    <= r3_xsow;
            r4_week    <= r3_week;
            r4_eweek   <= n4_eweek;
            r4_endw    <= r3_gal ? r3_week : n4_eweek;
            r4_esow    <= n4_esow;
            r4_q7200   <= n4_p7200[39:33];
        end
    end

    // ---------------- stage 5: begin floor, end wrap, output register
    logic [19:0]        n5_bsow, n5_esow;
    logic signed [15:0] n5_endw;

    logic               r5_ok;
    logic signed [15:0] r5_xweek, r5_eweek, r5_bweek, r5_endw;
    logic [19:0]        r5_xsow, r5_bsow, r5_esow;

    always_comb begin
        n5_bsow = (r4_gps && r4_nominal) ? 20'(r4_q7200) * SECS_TWO_HOURS : r4_xsow;
        if (r4_esow >= {1'b0, SECS_WEEK}) begin
            n5_esow = 20'(r4_esow - {1'b0, SECS_WEEK});
            n5_endw = r4_endw + 16'sd1;
        end else begin
            n5_esow = r4_esow[19:0];
            n5_endw = r4_endw;
        end
    end

    // drop every field for systems without a rule
    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_ok    <= r4_ok;
            r5_xweek <= r4_ok ? r4_week  : '0;
            r5_xsow  <= r4_ok ? r4_xsow  : '0;
            r5_eweek <= r4_ok ? r4_eweek : '0;
            r5_bweek <= r4_ok ? r4_week  : '0;
            r5_bsow  <= r4_ok ? n5_bsow  : '0;
            r5_endw  <= r4_ok ? n5_endw  : '0;
            r5_esow  <= r4_ok ? n5_esow  : '0;
        end
    end

    assign o_valid      = r_v5;
    assign o_valid_res  = r5_ok;
    assign o_xmit_week  = r5_xweek;
    assign o_xmit_sow   = r5_xsow;
    assign o_epoch_week = r5_eweek;
    assign o_begin_week = r5_bweek;
    assign o_begin_sow  = r5_bsow;
    assign o_end_week   = r5_endw;
    assign o_end_sow    = r5_esow;

    // ---------------- assertions
    `EVT_ASSERT_ALWAYS(a_reset_empties, i_clk,
        !i_rst_n |=> !o_valid, "output valid after reset")
    `EVT_ASSERT(a_accept_lands, i_clk, i_rst_n,
        (i_valid && o_ready) |=> r_v1, "accepted item lost at entry")
    `EVT_ASSERT(a_sow_range, i_clk, i_rst_n,
        o_valid |-> (o_xmit_sow < SECS_WEEK && o_begin_sow < SECS_WEEK
                     && o_end_sow < SECS_WEEK), "second of week out of range")
    `EVT_ASSERT(a_begin_le_xmit, i_clk, i_rst_n,
        o_valid |-> (o_begin_sow <= o_xmit_sow), "begin after transmit")
    `EVT_ASSERT(a_norule_zero, i_clk, i_rst_n,
        (o_valid && !o_valid_res) |-> (o_xmit_week == 16'sd0 && o_end_sow == 20'd0
                                       && o_begin_sow == 20'd0),
        "fields not cleared without rule")

endmodule

`default_nettype wire
